// ===== sv/drrm_pkg.sv =====
// Shared types, constants and field helpers for the dual-role key remapper.
`default_nettype none

package drrm_pkg;

  localparam int NSLOTS    = 8;
  localparam int SLOT_W    = 3;
  localparam int CODE_W    = 10;
  localparam int ENTRY_W   = 30;
  localparam int VALUE_W   = 2;
  localparam int CFG_IDX_W = 4;

  // Input event values
  localparam logic [VALUE_W-1:0] KEY_RELEASE = 2'd0;
  localparam logic [VALUE_W-1:0] KEY_PRESS   = 2'd1;

  typedef logic [ENTRY_W-1:0] entry_t;
  typedef logic [CODE_W-1:0]  code_t;
  typedef logic [SLOT_W-1:0]  slot_t;

  // Work handed from the front to the back
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_DUAL_REL,
    CMD_PLAIN_PRESS,
    CMD_PLAIN_REL
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    slot_t   slot;
    code_t   code;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_FLUSH,
    B_TAP_PRESS,
    B_FINAL
  } back_state_t;

  function automatic code_t ent_key(input entry_t e);
    return e[9:0];
  endfunction

  function automatic code_t ent_pri(input entry_t e);
    return e[19:10];
  endfunction

  function automatic code_t ent_sec(input entry_t e);
    return e[29:20];
  endfunction

endpackage

`default_nettype wire

// ===== sv/drrm_front.sv =====
// Front end: table lookup and classification of incoming key items.
`default_nettype none

module drrm_front import drrm_pkg::*; #(
  parameter int ENTRIES = 8
) (
  input  wire logic   rst,
  input  wire entry_t entries [NSLOTS],
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire code_t  key_code,
  input  wire logic [VALUE_W-1:0] key_value,
  output logic        push,
  output cmd_t        push_cmd,
  input  wire logic   fifo_ready
);

  logic  hit;
  logic  dual;
  slot_t hit_slot;
  code_t hit_pri;
  logic  is_press;
  logic  is_event;

  // First matching entry wins
  always_comb begin
    hit      = 1'b0;
    dual     = 1'b0;
    hit_slot = '0;
    hit_pri  = '0;
    for (int i = 0; i < NSLOTS; i++) begin
      if (i < ENTRIES && !hit && ent_key(entries[i]) == key_code) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(i);
        hit_pri  = ent_pri(entries[i]);
        dual     = (ent_sec(entries[i]) != '0);
      end
    end
  end

  // Classify the item; autorepeat and unknown values are dropped
  always_comb begin
    is_press      = (key_value == KEY_PRESS);
    is_event      = is_press || (key_value == KEY_RELEASE);
    push_cmd.slot = hit_slot;
    push_cmd.code = hit ? hit_pri : key_code;
    if (dual) begin
      push_cmd.op = is_press ? CMD_HOLD : CMD_DUAL_REL;
    end else begin
      push_cmd.op = is_press ? CMD_PLAIN_PRESS : CMD_PLAIN_REL;
    end
    in_ready = fifo_ready && !rst;
    push     = in_valid && in_ready && is_event;
  end

endmodule

`default_nettype wire

// ===== sv/drrm_cmd_fifo.sv =====
// Two-deep command queue between front and back.
`default_nettype none

module drrm_cmd_fifo import drrm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      fifo_ready,
  output logic      cmd_valid,
  output cmd_t      cmd,
  input  wire logic pop
);

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign fifo_ready = (count != 2'd2);
  assign cmd_valid  = (count != 2'd0);
  assign cmd        = mem[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/drrm_back.sv =====
// Back end: key state, secondary flush sequencing and output register.
`default_nettype none

module drrm_back import drrm_pkg::*; #(
  parameter int ENTRIES = 8
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire entry_t entries [NSLOTS],
  input  wire logic   cmd_valid,
  input  wire cmd_t   cmd,
  output logic        pop,
  output logic        out_valid,
  input  wire logic   out_ready,
  output code_t       out_code,
  output logic        out_value,
  output logic        last_of_run
);

  back_state_t       state;
  back_state_t       state_next;
  code_t             cur_code;
  logic              cur_value;
  logic              cur_tap;
  logic [NSLOTS-1:0] held;
  logic [NSLOTS-1:0] sent;

  logic              can_emit;
  logic              emit;
  code_t             emit_code;
  logic              emit_value;
  logic              emit_last;
  logic              flush_any;
  slot_t             flush_slot;
  code_t             flush_code;

  // Find the lowest held dual-role key whose secondary press is unsent
  always_comb begin
    flush_any  = 1'b0;
    flush_slot = '0;
    flush_code = '0;
    for (int i = 0; i < NSLOTS; i++) begin
      if (i < ENTRIES && !flush_any && held[i] && !sent[i] &&
          ent_sec(entries[i]) != '0) begin
        flush_any  = 1'b1;
        flush_slot = SLOT_W'(i);
        flush_code = ent_sec(entries[i]);
      end
    end
  end

  // Sequencer next state and emit decisions
  always_comb begin
    can_emit   = !out_valid || out_ready;
    state_next = state;
    pop        = 1'b0;
    emit       = 1'b0;
    emit_code  = cur_code;
    emit_value = cur_value;
    emit_last  = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          pop = 1'b1;
          unique case (cmd.op)
            CMD_HOLD:        state_next = B_IDLE;
            CMD_DUAL_REL:    state_next = sent[cmd.slot] ? B_FINAL : B_FLUSH;
            CMD_PLAIN_PRESS: state_next = B_FLUSH;
            CMD_PLAIN_REL:   state_next = B_FINAL;
            default:         state_next = B_IDLE;
          endcase
        end
      end
      B_FLUSH: begin
        if (flush_any) begin
          if (can_emit) begin
            emit       = 1'b1;
            emit_code  = flush_code;
            emit_value = 1'b1;
          end
        end else begin
          state_next = cur_tap ? B_TAP_PRESS : B_FINAL;
        end
      end
      B_TAP_PRESS: begin
        if (can_emit) begin
          emit       = 1'b1;
          emit_value = 1'b1;
          state_next = B_FINAL;
        end
      end
      B_FINAL: begin
        if (can_emit) begin
          emit       = 1'b1;
          emit_last  = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the command being carried out
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_code  <= (cmd.op == CMD_DUAL_REL && sent[cmd.slot]) ?
                   ent_sec(entries[cmd.slot]) : cmd.code;
      cur_value <= (cmd.op == CMD_PLAIN_PRESS);
      cur_tap   <= (cmd.op == CMD_DUAL_REL);
    end
  end

  // Track held keys and sent secondary presses
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
      sent <= '0;
    end else begin
      if (pop && cmd.op == CMD_HOLD) begin
        held[cmd.slot] <= 1'b1;
      end
      if (pop && cmd.op == CMD_DUAL_REL) begin
        held[cmd.slot] <= 1'b0;
        sent[cmd.slot] <= 1'b0;
      end
      if (state == B_FLUSH && emit) begin
        sent[flush_slot] <= 1'b1;
      end
    end
  end

  // Output register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_code    <= emit_code;
      out_value   <= emit_value;
      last_of_run <= emit_last;
    end
  end

endmodule

`default_nettype wire

// ===== sv/dual_role_key_remapper.sv =====
// Each accepted item runs through the front-end lookup, the two-deep command queue and the
// back-end sequencer, which sets the pace and shows results from its output register. A
// flush pass runs on a plain press or a dual-role tap; an item yields up to nine results,
// dropped items none. The back end pops the next command only once the last one is done,
// and the queue lets the front accept items meanwhile. Reset (synchronous, active high)
// clears the table, queue, key state, sequencer state and output valid flag.
`default_nettype none

module dual_role_key_remapper import drrm_pkg::*; #(
  parameter int ENTRIES = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [CODE_W-1:0]    key_code,
  input  wire logic [VALUE_W-1:0]   key_value,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [CODE_W-1:0]         out_code,
  output logic                      out_value,
  output logic                      last_of_run,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ENTRY_W-1:0]   cfg_data
);

  entry_t entries [NSLOTS];
  logic   push;
  cmd_t   push_cmd;
  logic   fifo_ready;
  logic   cmd_valid;
  cmd_t   cmd;
  logic   pop;

  assign cfg_ready = 1'b1;

  // Table registers; out-of-range indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSLOTS; i++) begin
        entries[i] <= '0;
      end
    end else if (cfg_valid && cfg_index < CFG_IDX_W'(NSLOTS)) begin
      entries[cfg_index[SLOT_W-1:0]] <= cfg_data;
    end
  end

  drrm_front #(.ENTRIES(ENTRIES)) u_front (
    .rst        (rst),
    .entries    (entries),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .key_code   (key_code),
    .key_value  (key_value),
    .push       (push),
    .push_cmd   (push_cmd),
    .fifo_ready (fifo_ready)
  );

  drrm_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .fifo_ready (fifo_ready),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .pop        (pop)
  );

  drrm_back #(.ENTRIES(ENTRIES)) u_back (
    .clk         (clk),
    .rst         (rst),
    .entries     (entries),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_code    (out_code),
    .out_value   (out_value),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire

// ===== sv/drrm_checker.sv =====
// Port-level checks for the dual-role key remapper, bound to the top level.
`default_nettype none

module drrm_checker import drrm_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [CODE_W-1:0]    out_code,
  input wire logic                 out_value,
  input wire logic                 last_of_run,
  input wire logic                 cfg_valid,
  input wire logic                 cfg_ready
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_code) &&
                                $stable(out_value) && $stable(last_of_run))
    else $error("result changed while stalled");

  // Reset empties the output register
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // Only presses can precede the last event of a run
  a_mid_press: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> out_value)
    else $error("release event not marked last of run");

  // Input is refused during reset
  a_rst_in: assert property (@(posedge clk) rst |-> !in_ready)
    else $error("input accepted during reset");

  // Configuration writes are never stalled
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind dual_role_key_remapper drrm_checker u_drrm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_code    (out_code),
  .out_value   (out_value),
  .last_of_run (last_of_run),
  .cfg_valid   (cfg_valid),
  .cfg_ready   (cfg_ready)
);

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the dual-role key remapper: directed and random key traffic.
module tb;
  import drrm_pkg::*;

  localparam int N_ACTIVE     = 8;
  localparam int MAX_RUN      = 9;
  localparam int DRAIN_CYCLES = 30;
  localparam int PHASE_ITEMS  = 133;

  // Event values the package leaves out
  localparam logic [VALUE_W-1:0] KEY_AUTOREPEAT = 2'd2;
  localparam logic [VALUE_W-1:0] KEY_UNUSED     = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_0     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 4'd15;

  typedef struct packed {
    code_t code;
    logic  value;
    logic  last;
  } key_event_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [CODE_W-1:0]    key_code  = '0;
  logic [VALUE_W-1:0]   key_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CODE_W-1:0]    out_code;
  logic                 out_value;
  logic                 last_of_run;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ENTRY_W-1:0]   cfg_data  = '0;

  // Mirror of the remap table and the per-entry key state
  entry_t     entry_tbl [NSLOTS];
  logic       key_down  [NSLOTS];
  logic       sec_out   [NSLOTS];
  key_event_t run_buf[$];
  key_event_t pending_events[$];

  int mismatches    = 0;
  int send_idle_pct = 30;
  int recv_idle_pct = 47;

  dual_role_key_remapper #(.ENTRIES(N_ACTIVE)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .key_code(key_code), .key_value(key_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_code(out_code),
    .out_value(out_value), .last_of_run(last_of_run),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- remap prediction

  function automatic code_t key_of(int i);
    return entry_tbl[i][9:0];
  endfunction

  function automatic code_t primary_of(int i);
    return entry_tbl[i][19:10];
  endfunction

  function automatic code_t secondary_of(int i);
    return entry_tbl[i][29:20];
  endfunction

  function automatic entry_t make_entry(code_t k, code_t pri, code_t sec);
    return {sec, pri, k};
  endfunction

  // First matching entry wins; -1 when the key is not in the table
  function automatic int find_entry(code_t k);
    for (int i = 0; i < N_ACTIVE; i++)
      if (key_of(i) == k) return i;
    return -1;
  endfunction

  function automatic void add_event(code_t c, logic v);
    key_event_t ev;
    if (run_buf.size() >= MAX_RUN) return;
    ev.code  = c;
    ev.value = v;
    ev.last  = 1'b0;
    run_buf.push_back(ev);
  endfunction

  // Send the secondary press of every held dual-role key that has not sent it yet
  function automatic void flush_held_keys();
    for (int i = 0; i < N_ACTIVE; i++) begin
      if (key_down[i] && secondary_of(i) != '0 && !sec_out[i]) begin
        add_event(secondary_of(i), 1'b1);
        sec_out[i] = 1'b1;
      end
    end
  endfunction

  function automatic void predict_remap(code_t k, logic [VALUE_W-1:0] v);
    int         idx;
    code_t      oc;
    key_event_t ev;
    run_buf.delete();
    if (v != KEY_PRESS && v != KEY_RELEASE) return;
    idx = find_entry(k);
    if (idx >= 0 && secondary_of(idx) != '0) begin
      if (v == KEY_PRESS) begin
        key_down[idx] = 1'b1;
      end else begin
        key_down[idx] = 1'b0;
        if (sec_out[idx]) begin
          add_event(secondary_of(idx), 1'b0);
          sec_out[idx] = 1'b0;
        end else begin
          flush_held_keys();
          add_event(primary_of(idx), 1'b1);
          add_event(primary_of(idx), 1'b0);
        end
      end
    end else begin
      oc = (idx >= 0) ? primary_of(idx) : k;
      if (v == KEY_PRESS) flush_held_keys();
      add_event(oc, v == KEY_PRESS);
    end
    foreach (run_buf[i]) begin
      ev      = run_buf[i];
      ev.last = (i == run_buf.size() - 1);
      pending_events.push_back(ev);
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  // Offer one key item with random gaps ahead of it; valid stays up after acceptance
  task automatic send_key(code_t k, logic [VALUE_W-1:0] v);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    key_code  <= k;
    key_value <= v;
    do @(posedge clk); while (!in_ready);
    predict_remap(k, v);
  endtask

  // Drop valid, wait for every expected event, then let the back end go quiet
  task automatic drain_outputs();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_entry(logic [CFG_IDX_W-1:0] idx, entry_t data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NSLOTS) entry_tbl[idx[SLOT_W-1:0]] = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random stalls on the result side
  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Compare each accepted event with the oldest prediction
  always @(posedge clk) begin : check_events
    key_event_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        $error("unexpected event: out_code=%0d out_value=%0d last_of_run=%0d",
               out_code, out_value, last_of_run);
        mismatches++;
      end else begin
        want = pending_events.pop_front();
        if (out_code !== want.code) begin
          $error("out_code: expected %0d, got %0d", want.code, out_code);
          mismatches++;
        end
        if (out_value !== want.value) begin
          $error("out_value: expected %0d, got %0d", want.value, out_value);
          mismatches++;
        end
        if (last_of_run !== want.last) begin
          $error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // Unmapped keys, remapped plain keys, shadowed duplicates, ignored values
  task automatic test_plain_keys();
    write_entry(REG_ENTRY_0, make_entry(10'd5, 10'd300, 10'd0));
    write_entry(CFG_IDX_W'(REG_ENTRY_0 + 1), make_entry(10'd5, 10'd400, 10'd600));
    write_entry(CFG_IDX_W'(REG_ENTRY_0 + 2), '1);
    for (int j = 0; j < 5; j++)
      write_entry(CFG_IDX_W'(REG_ENTRY_0 + 3 + j),
                  make_entry(code_t'(10 + j), code_t'(200 + j), code_t'(100 + j)));
    write_entry(REG_UNMAPPED_LO, '1);
    write_entry(REG_UNMAPPED_HI, '1);
    send_key(10'd0, KEY_PRESS);
    send_key(10'd0, KEY_RELEASE);
    send_key(10'd5, KEY_PRESS);
    send_key(10'd5, KEY_RELEASE);
    send_key(10'd5, KEY_AUTOREPEAT);
    send_key(10'd1023, KEY_UNUSED);
    send_key(10'd700, KEY_PRESS);
    send_key(10'd700, KEY_RELEASE);
  endtask

  // Tap, hold with flush on a plain press, held release, release without press
  task automatic test_dual_role_keys();
    send_key(10'd10, KEY_PRESS);
    send_key(10'd10, KEY_RELEASE);
    send_key(10'd11, KEY_PRESS);
    send_key(10'd1023, KEY_PRESS);
    send_key(10'd5, KEY_PRESS);
    send_key(10'd5, KEY_RELEASE);
    send_key(10'd11, KEY_RELEASE);
    send_key(10'd1023, KEY_RELEASE);
    send_key(10'd12, KEY_RELEASE);
  endtask

  // Rewrite the table while a key is held, then drive a longest run
  task automatic test_table_rewrite();
    send_key(10'd13, KEY_PRESS);
    drain_outputs();
    write_entry(CFG_IDX_W'(REG_ENTRY_0 + 6), make_entry(10'd13, 10'd50, 10'd0));
    send_key(10'd0, KEY_PRESS);
    drain_outputs();
    for (int i = 0; i < NSLOTS; i++)
      write_entry(CFG_IDX_W'(REG_ENTRY_0 + i),
                  make_entry(code_t'(20 + i), code_t'(500 + i), code_t'(900 + i)));
    for (int i = 0; i < 6; i++)
      send_key(code_t'(20 + i), KEY_PRESS);
    send_key(10'd27, KEY_RELEASE);
  endtask

  function automatic entry_t random_entry();
    code_t k, pri, sec;
    k   = code_t'($urandom_range(0, 31));
    pri = code_t'($urandom_range(0, 1023));
    sec = ($urandom_range(0, 99) < 35) ? '0 : code_t'($urandom_range(1, 1023));
    return make_entry(k, pri, sec);
  endfunction

  // Three phases of random traffic, each with a fresh table and its own idling
  task automatic test_random_traffic();
    entry_t                data;
    code_t                 k;
    logic [VALUE_W-1:0]    v;
    int                    r;
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 30 : (p == 1) ? 47 : 0;
      recv_idle_pct = (p == 0) ? 47 : (p == 1) ? 30 : 0;
      drain_outputs();
      for (int i = 0; i < NSLOTS; i++) begin
        data = random_entry();
        if (p == 1 && i == 0) data = '1;
        if (p == 2 && i == NSLOTS - 1) data = '0;
        write_entry(CFG_IDX_W'(REG_ENTRY_0 + i), data);
      end
      write_entry(REG_UNMAPPED_LO + CFG_IDX_W'($urandom_range(0, 7)), entry_t'($urandom));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // mostly table keys so holds, flushes and taps interleave
        if ($urandom_range(0, 99) < 75) k = key_of($urandom_range(0, NSLOTS - 1));
        else k = code_t'($urandom_range(0, 1023));
        r = $urandom_range(0, 99);
        if (r < 45) v = KEY_PRESS;
        else if (r < 90) v = KEY_RELEASE;
        else if (r < 95) v = KEY_AUTOREPEAT;
        else v = KEY_UNUSED;
        send_key(k, v);
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    for (int i = 0; i < NSLOTS; i++) begin
      entry_tbl[i] = '0;
      key_down[i]  = 1'b0;
      sec_out[i]   = 1'b0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_plain_keys();
    test_dual_role_keys();
    test_table_rewrite();
    test_random_traffic();
    drain_outputs();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
